// ===== design/jtc_pkg.sv =====
// jtc_pkg: types, constants and per-joint gain tables for the joint torque controller
// no dependencies; used by jtc_ctrl, jtc_datapath and joint_torque_controller

package jtc_pkg;

    // control law codes held in the mode register
    localparam logic [1:0] MODE_POS    = 2'd0;
    localparam logic [1:0] MODE_VEL    = 2'd1;
    localparam logic [1:0] MODE_TORQUE = 2'd2;

    // operand selections for the shared multiplier
    localparam logic [1:0] MUL_QUOT = 2'd0;
    localparam logic [1:0] MUL_GAIN = 2'd1;
    localparam logic [1:0] MUL_AUX  = 2'd2;

    // velocity error magnitude is capped here before the divide by 1000;
    // beyond it the integrator saturates anyway
    localparam logic [26:0] ERR_CAP    = 27'd65537000;
    // ceil(2^37 / 1000), exact floor quotient for any value up to ERR_CAP
    localparam logic [27:0] RECIP_1000 = 28'd137438954;
    localparam int          RECIP_SH   = 37;

    // integrator bound and slew step, both 0.5 in q16.16
    localparam logic signed [16:0] INTEG_MAX = 17'sd32768;
    localparam logic signed [32:0] SLEW_STEP = 33'sd32768;

    // width of the unclamped torque sum
    localparam int TAU_W = 41;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       err;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc;
        logic       sum;
        logic       lim;
        logic       fin;
    } jtc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_blocked;
    } jtc_status_t;

    // proportional gain for velocity pi
    function automatic logic [5:0] kp_gain(input logic [2:0] j);
        case (j)
            3'd0, 3'd1, 3'd2, 3'd3: kp_gain = 6'd40;
            3'd4:                   kp_gain = 6'd25;
            3'd5:                   kp_gain = 6'd20;
            default:                kp_gain = 6'd18;
        endcase
    endfunction

    // integral gain for velocity pi, q16.16
    function automatic logic [18:0] ki_gain(input logic [2:0] j);
        case (j)
            3'd0, 3'd1, 3'd2, 3'd3: ki_gain = 19'd262144;
            3'd4:                   ki_gain = 19'd163840;
            3'd5:                   ki_gain = 19'd131072;
            default:                ki_gain = 19'd117965;
        endcase
    endfunction

    // stiffness for position pd
    function automatic logic [5:0] k_gain(input logic [2:0] j);
        case (j)
            3'd0, 3'd1, 3'd2, 3'd3: k_gain = 6'd60;
            3'd4:                   k_gain = 6'd40;
            3'd5:                   k_gain = 6'd30;
            default:                k_gain = 6'd25;
        endcase
    endfunction

    // damping for position pd
    function automatic logic [4:0] d_gain(input logic [2:0] j);
        case (j)
            3'd0, 3'd1, 3'd2, 3'd3: d_gain = 5'd18;
            3'd4:                   d_gain = 5'd12;
            3'd5:                   d_gain = 5'd10;
            default:                d_gain = 5'd8;
        endcase
    endfunction

    // torque limit in whole nm
    function automatic logic [5:0] torque_limit(input logic [2:0] j);
        case (j)
            3'd0, 3'd1, 3'd2, 3'd3: torque_limit = 6'd60;
            3'd4, 3'd5:             torque_limit = 6'd35;
            default:                torque_limit = 6'd30;
        endcase
    endfunction

endpackage

// ===== design/jtc_ctrl.sv =====
// jtc_ctrl: sequencing state machine of the joint torque controller
// depends on jtc_pkg for the command and status structs and multiplier codes

module jtc_ctrl
    import jtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  jtc_status_t status,
    output jtc_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_QUOT = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_GAIN = 4'd4;
    localparam logic [3:0] S_AUX  = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_LIM  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // one request in work at a time
    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_QUOT;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_ERR;
                end
            end
            S_ERR:
            begin
                cmd.err    = 1'b1;
                state_next = S_QUOT;
            end
            S_QUOT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_QUOT;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN;
                state_next  = S_AUX;
            end
            S_AUX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_AUX;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_LIM;
            end
            S_LIM:
            begin
                cmd.lim    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register can take the result
                if (!status.out_blocked)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/jtc_datapath.sv =====
// jtc_datapath: operand registers, shared multiplier, per-joint state and output register
// depends on jtc_pkg for gain tables, constants and the command and status structs

module jtc_datapath
    import jtc_pkg::*;
#(
    parameter int NUM_JOINTS = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  jtc_cmd_t           cmd,
    output jtc_status_t        status,
    input  logic               control_mode_we,
    input  logic [1:0]         control_mode_wdata,
    input  logic [2:0]         joint_index,
    input  logic signed [31:0] joint_position,
    input  logic signed [31:0] joint_velocity,
    input  logic signed [31:0] position_target,
    input  logic signed [31:0] velocity_target,
    input  logic signed [31:0] torque_target,
    input  logic signed [31:0] gravity_torque,
    input  logic               command_fresh,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         joint_out,
    output logic signed [31:0] drive_torque
);

    localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int JW    = (IDX_W > 3) ? IDX_W : 3;

    // configuration
    logic [1:0] mode_reg;

    // captured request
    logic [2:0]         joint_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] dq_reg;
    logic signed [31:0] q_t_reg;
    logic signed [31:0] dq_t_reg;
    logic signed [31:0] tau_t_reg;
    logic signed [31:0] grav_reg;
    logic               fresh_reg;

    // intermediate values
    logic               pi_reg;
    logic               torque_reg;
    logic               in_range_reg;
    logic signed [32:0] e_sel_reg;
    logic               e_neg_reg;
    logic [26:0]        clip_reg;
    logic [16:0]        quot_reg;
    logic signed [16:0] acc_reg;
    logic signed [TAU_W-1:0] pa_reg;
    logic signed [TAU_W-1:0] pb_reg;
    logic signed [TAU_W-1:0] tau_reg;
    logic signed [31:0] t_reg;

    // per-joint state
    logic signed [16:0] integ_reg [NUM_JOINTS];
    logic signed [31:0] prev_reg  [NUM_JOINTS];

    // output register
    logic               out_valid_reg;
    logic [2:0]         joint_out_reg;
    logic signed [31:0] drive_reg;

    logic [JW-1:0]      jext;
    logic [IDX_W-1:0]   idx;

    assign jext = JW'(joint_reg);
    assign idx  = jext[IDX_W-1:0];

    function automatic logic signed [32:0] position_target_sx(input logic signed [31:0] v);
        position_target_sx = 33'(v);
    endfunction

    // error terms
    logic signed [32:0] e_pos;
    logic signed [32:0] e_vel;
    logic [32:0]        e_vel_abs;
    logic               pi_sel;

    assign e_pos     = 33'(position_target_sx(q_t_reg)) - 33'(position_target_sx(q_reg));
    assign e_vel     = 33'(position_target_sx(dq_t_reg)) - 33'(position_target_sx(dq_reg));
    assign e_vel_abs = e_vel[32] ? 33'(-e_vel) : 33'(e_vel);
    assign pi_sel    = (mode_reg == MODE_VEL) && fresh_reg;

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [28:0] mul_b;
    logic signed [62:0] prod;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_QUOT:
            begin
                mul_a = signed'({7'd0, clip_reg});
                mul_b = signed'({1'b0, RECIP_1000});
            end
            MUL_GAIN:
            begin
                mul_a = 34'(e_sel_reg);
                mul_b = pi_reg ? signed'(29'(kp_gain(joint_reg)))
                               : signed'(29'(k_gain(joint_reg)));
            end
            MUL_AUX:
            begin
                mul_a = pi_reg ? 34'(acc_reg) : 34'(dq_reg);
                mul_b = pi_reg ? signed'(29'(ki_gain(joint_reg)))
                               : signed'(29'(d_gain(joint_reg)));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 63'(mul_a) * 63'(mul_b);

    // integrator update with saturation
    logic signed [17:0] sq;
    logic signed [18:0] isum;
    logic signed [16:0] acc_next;

    assign sq   = e_neg_reg ? 18'(-signed'({1'b0, quot_reg})) : signed'({1'b0, quot_reg});
    assign isum = 19'(integ_reg[idx]) + 19'(sq);

    always_comb
    begin
        if (isum > 19'(INTEG_MAX))
        begin
            acc_next = INTEG_MAX;
        end
        else if (isum < 19'(-INTEG_MAX))
        begin
            acc_next = -INTEG_MAX;
        end
        else
        begin
            acc_next = isum[16:0];
        end
    end

    // control law sum
    logic signed [TAU_W-1:0] tau_next;

    always_comb
    begin
        if (torque_reg)
        begin
            tau_next = TAU_W'(tau_t_reg) - TAU_W'(grav_reg);
        end
        else if (pi_reg)
        begin
            tau_next = pa_reg + pb_reg;
        end
        else
        begin
            tau_next = pa_reg - pb_reg;
        end
    end

    // torque limit clamp
    logic signed [TAU_W-1:0] lim;
    logic signed [31:0]      t_next;

    assign lim = signed'(TAU_W'({torque_limit(joint_reg), 16'd0}));

    always_comb
    begin
        if (tau_reg > lim)
        begin
            t_next = lim[31:0];
        end
        else if (tau_reg < -lim)
        begin
            t_next = 32'(-lim);
        end
        else
        begin
            t_next = tau_reg[31:0];
        end
    end

    // slew limit against the joint's last output
    logic signed [31:0] last;
    logic signed [32:0] delta;
    logic signed [31:0] slew_t;

    assign last  = prev_reg[idx];
    assign delta = 33'(t_reg) - 33'(last);

    always_comb
    begin
        if (delta > SLEW_STEP)
        begin
            slew_t = 32'(33'(last) + SLEW_STEP);
        end
        else if (delta < -SLEW_STEP)
        begin
            slew_t = 32'(33'(last) - SLEW_STEP);
        end
        else
        begin
            slew_t = t_reg;
        end
    end

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_POS;
        end
        else if (control_mode_we)
        begin
            mode_reg <= control_mode_wdata;
        end
    end

    // request capture and arithmetic steps
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            joint_reg <= joint_index;
            q_reg     <= joint_position;
            dq_reg    <= joint_velocity;
            q_t_reg   <= position_target;
            dq_t_reg  <= velocity_target;
            tau_t_reg <= torque_target;
            grav_reg  <= gravity_torque;
            fresh_reg <= command_fresh;
        end
        if (cmd.err)
        begin
            pi_reg       <= pi_sel;
            torque_reg   <= (mode_reg == MODE_TORQUE);
            in_range_reg <= (32'(joint_reg) < NUM_JOINTS);
            e_sel_reg    <= pi_sel ? e_vel : e_pos;
            e_neg_reg    <= e_vel[32];
            clip_reg     <= (e_vel_abs > 33'(ERR_CAP)) ? ERR_CAP : e_vel_abs[26:0];
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MUL_QUOT: quot_reg <= prod[RECIP_SH+16:RECIP_SH];
                MUL_GAIN: pa_reg   <= prod[TAU_W-1:0];
                MUL_AUX:  pb_reg   <= pi_reg ? TAU_W'(prod >>> 16) : prod[TAU_W-1:0];
                default:  pa_reg   <= pa_reg;
            endcase
        end
        if (cmd.acc)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.sum)
        begin
            tau_reg <= tau_next;
        end
        if (cmd.lim)
        begin
            t_reg <= t_next;
        end
    end

    // per-joint integrator and last output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end
        else if (cmd.fin && in_range_reg)
        begin
            prev_reg[idx] <= slew_t;
            if (torque_reg)
            begin
                integ_reg[idx] <= '0;
            end
            else if (pi_reg)
            begin
                integ_reg[idx] <= acc_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            joint_out_reg <= joint_reg;
            drive_reg     <= in_range_reg ? slew_t : 32'sd0;
        end
    end

    assign status.out_blocked = out_valid_reg && out_stall;
    assign out_valid          = out_valid_reg;
    assign joint_out          = joint_out_reg;
    assign drive_torque       = drive_reg;

endmodule

// ===== design/joint_torque_controller.sv =====
// joint_torque_controller: top level, joins the sequencer and the datapath
// depends on jtc_pkg, jtc_ctrl and jtc_datapath

// Per-joint torque controller in signed q16.16. Each request carries one joint
// sample; the mode register picks position pd, velocity pi (only with a fresh
// command, otherwise pd) or torque pass-through minus gravity, which also clears
// the joint's integrator. The result is clamped to the joint's torque limit and
// moved at most 0.5 nm from that joint's previous output. A joint index at or
// above NUM_JOINTS returns zero torque and leaves all state alone. One request
// is in work at a time: the sequencer steps one shared multiplier through the
// divide by 1000, the gain product and the damping or integral product, then
// forms the sum, the clamp and the slew step. It waits in its last step while
// the output register is blocked, and takes the next request once it is back
// in idle. A finished result waits in the output register while the next
// request is taken. Write the mode register only while the block is idle.

module joint_torque_controller
    import jtc_pkg::*;
#(
    parameter int NUM_JOINTS = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               control_mode_we,
    input  logic [1:0]         control_mode_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         joint_index,
    input  logic signed [31:0] joint_position,
    input  logic signed [31:0] joint_velocity,
    input  logic signed [31:0] position_target,
    input  logic signed [31:0] velocity_target,
    input  logic signed [31:0] torque_target,
    input  logic signed [31:0] gravity_torque,
    input  logic               command_fresh,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         joint_out,
    output logic signed [31:0] drive_torque
);

    jtc_cmd_t    cmd;
    jtc_status_t status;

    // sequencer
    jtc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and state
    jtc_datapath #(
        .NUM_JOINTS (NUM_JOINTS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .control_mode_we    (control_mode_we),
        .control_mode_wdata (control_mode_wdata),
        .joint_index        (joint_index),
        .joint_position     (joint_position),
        .joint_velocity     (joint_velocity),
        .position_target    (position_target),
        .velocity_target    (velocity_target),
        .torque_target      (torque_target),
        .gravity_torque     (gravity_torque),
        .command_fresh      (command_fresh),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .joint_out          (joint_out),
        .drive_torque       (drive_torque)
    );

endmodule
